// ===== rtl/ssm_pkg.sv =====
`timescale 1ns / 1ps

package ssm_pkg;

  // Pattern register file is fixed at two 64-bit words
  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned PAT_IDX_W = 4;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned OFFSET_W = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_PATTERN_DEFAULT = 16;
  localparam int unsigned MAX_STARTS_DEFAULT = 2048;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 2'd2;

  typedef logic [PAT_BYTES-1:0][7:0] pat_t;

endpackage

// ===== rtl/ssm_cell.sv =====
`timescale 1ns / 1ps

module ssm_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                     clk,
  input  logic                     shift_en,
  input  logic [7:0]               byte_in,
  input  ssm_pkg::pat_t            pat,
  input  logic [ssm_pkg::LEN_W-1:0] act_len,
  output logic [7:0]               byte_out,
  output logic                     hit
);
  import ssm_pkg::*;

  localparam logic [LEN_W-1:0] CellIdx = LEN_W'(IDX);

  logic [7:0]       stored;
  logic [LEN_W-1:0] pidx;

  // cell k sees pattern byte len-1-k once the new byte lands here
  assign pidx = act_len - CellIdx - LEN_W'(1);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      stored <= byte_in;
    end
  end

  assign byte_out = stored;
  assign hit = (act_len <= CellIdx) || (byte_in == pat[pidx[PAT_IDX_W-1:0]]);

endmodule

// ===== rtl/ssm_track.sv =====
`timescale 1ns / 1ps

module ssm_track #(
  parameter int unsigned MAX_STARTS = ssm_pkg::MAX_STARTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        is_last,
  input  logic                        all_hit,
  input  logic [ssm_pkg::LEN_W-1:0]   act_len,
  input  logic                        out_ready,
  output logic                        in_ready,
  output logic                        shift_en,
  output logic                        out_valid,
  output logic                        found,
  output logic [ssm_pkg::OFFSET_W-1:0] match_offset
);
  import ssm_pkg::*;

  localparam logic [COUNT_W:0] StartLimit = (COUNT_W+1)'(MAX_STARTS);

  logic [COUNT_W-1:0]  bytes_seen;
  logic                count_overflow;
  logic                match_seen;
  logic [OFFSET_W-1:0] first_offset;

  logic [COUNT_W-1:0]  bytes_seen_next;
  logic                count_overflow_next;
  logic                match_seen_next;
  logic [OFFSET_W-1:0] first_offset_next;
  logic                found_next;

  logic                step;
  logic                can_count;
  logic [COUNT_W-1:0]  seen_inc;
  logic [COUNT_W-1:0]  len_ext;
  logic [COUNT_W-1:0]  start;
  logic [COUNT_W-1:0]  span;

  // only a last beat needs the result register; other beats pass a waiting result
  assign in_ready  = !out_valid || out_ready || !is_last;
  assign step      = in_valid && in_ready;
  assign can_count = (bytes_seen != COUNT_MAX);
  assign shift_en  = step && can_count;
  assign seen_inc  = bytes_seen + COUNT_W'(1);
  assign len_ext   = COUNT_W'(act_len);
  assign start     = seen_inc - len_ext;

  always_comb begin
    bytes_seen_next     = bytes_seen;
    count_overflow_next = count_overflow;
    match_seen_next     = match_seen;
    first_offset_next   = first_offset;
    if (can_count) begin
      bytes_seen_next = seen_inc;
      if (!match_seen && (act_len != '0) && (seen_inc >= len_ext) && all_hit &&
          ({1'b0, start} < StartLimit)) begin
        match_seen_next   = 1'b1;
        first_offset_next = start[OFFSET_W-1:0];
      end
    end else begin
      count_overflow_next = 1'b1;
    end
  end

  assign span = bytes_seen_next - len_ext;
  // starts = span + 1 must not pass the limit
  assign found_next = (act_len != '0) && !count_overflow_next &&
                      (bytes_seen_next >= len_ext) && ({1'b0, span} < StartLimit) &&
                      match_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      count_overflow <= 1'b0;
      match_seen     <= 1'b0;
      first_offset   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        if (is_last) begin
          bytes_seen     <= '0;
          count_overflow <= 1'b0;
          match_seen     <= 1'b0;
          first_offset   <= '0;
          out_valid      <= 1'b1;
        end else begin
          bytes_seen     <= bytes_seen_next;
          count_overflow <= count_overflow_next;
          match_seen     <= match_seen_next;
          first_offset   <= first_offset_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_last) begin
      found        <= found_next;
      match_offset <= found_next ? first_offset_next : '0;
    end
  end

  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> ({2'b00, match_offset} < StartLimit))
    else $error("reported offset beyond start limit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> (match_offset == '0))
    else $error("offset not zero on a miss");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && is_last |=> (bytes_seen == '0) && !match_seen && !count_overflow && out_valid)
    else $error("stream state not cleared after last beat");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    step && !is_last && can_count |=> (bytes_seen == $past(seen_inc)))
    else $error("byte count did not advance");

  a_overflow_sat: assert property (@(posedge clk) disable iff (rst)
    count_overflow |-> (bytes_seen == COUNT_MAX))
    else $error("overflow flag without saturated count");

endmodule

// ===== rtl/stream_substring_matcher.sv =====
`timescale 1ns / 1ps

// Byte stream substring matcher.
// Load the pattern through the config channel (index 0: bytes 0-7, index 1:
// bytes 8-15, byte 0/8 in the low bits; index 2: length 0..16, 0 never
// matches) while no buffer is in flight. cfg_ready is always high.
// Bytes enter on the input channel, one beat per byte, is_last on the final
// byte of a buffer. Each accepted beat shifts a chain of byte cells until
// the byte count saturates; each cell compares its incoming byte against
// its pattern byte, so a byte is taken every cycle except a last byte held
// back as described below. One result beat (found, match_offset) leaves
// per buffer, in the cycle after the last byte is accepted, from an output
// register. Only a match starting within the first MAX_STARTS positions
// counts; buffers with over MAX_STARTS starts or past 4095 bytes report not found.
// While a result waits, only a last byte is held back, until the receiver
// takes the result; other bytes keep streaming at one per cycle. With
// out_ready high the input is never held back. Reset clears the pattern
// registers to zero and drops any buffer in progress and any pending result.
module stream_substring_matcher #(
  parameter int unsigned MAX_PATTERN = ssm_pkg::MAX_PATTERN_DEFAULT,
  parameter int unsigned MAX_STARTS  = ssm_pkg::MAX_STARTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [ssm_pkg::OFFSET_W-1:0]  match_offset
);
  import ssm_pkg::*;

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN);

  logic [63:0]      pat_low;
  logic [63:0]      pat_high;
  logic [LEN_W-1:0] pat_len;
  logic [LEN_W-1:0] act_len;
  pat_t             pat;

  logic [MAX_PATTERN-1:0]      hit;
  logic [MAX_PATTERN-1:0][7:0] win;
  logic                        shift_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAT_LOW:  pat_low  <= cfg_data;
        REG_PAT_HIGH: pat_high <= cfg_data;
        REG_PAT_LEN:  pat_len  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat     = {pat_high, pat_low};
  assign act_len = (pat_len > MaxLen) ? MaxLen : pat_len;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] feed;
    if (k == 0) begin : g_head
      assign feed = data_byte;
    end else begin : g_body
      assign feed = win[k-1];
    end
    ssm_cell #(
      .IDX(k)
    ) u_cell (
      .clk     (clk),
      .shift_en(shift_en),
      .byte_in (feed),
      .pat     (pat),
      .act_len (act_len),
      .byte_out(win[k]),
      .hit     (hit[k])
    );
  end

  ssm_track #(
    .MAX_STARTS(MAX_STARTS)
  ) u_track (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .is_last     (is_last),
    .all_hit     (&hit),
    .act_len     (act_len),
    .out_ready   (out_ready),
    .in_ready    (in_ready),
    .shift_en    (shift_en),
    .out_valid   (out_valid),
    .found       (found),
    .match_offset(match_offset)
  );

endmodule
